// ----- src/bis_pkg.sv -----
// Shared types, constants and helpers for the bitmap integer set.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bis_pkg;

  localparam int VAL_W        = 10;
  localparam int OP_W         = 3;
  localparam int CNT_W        = 11;
  localparam int WORD_W       = 64;
  localparam int WORD_LW      = 6;
  localparam int DEF_CAPACITY = 1024;
  localparam logic [VAL_W-1:0] LARGEST_RST = {VAL_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_TEST   = 3'd2,
    OP_SUCC   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_COMPL  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACCESS,
    ST_SCAN,
    ST_CMPL
  } state_t;

  // Control strobes from the sequencer to the word memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_all;
  } mem_ctl_t;

  typedef struct packed {
    logic               found;
    logic [WORD_LW-1:0] idx;
  } ffs_t;

  // Lowest set bit of a bitmap word.
  function automatic ffs_t find_first(input logic [WORD_W-1:0] w);
    ffs_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        r.found = 1'b1;
        r.idx   = i[WORD_LW-1:0];
      end
    end
    return r;
  endfunction

endpackage

// ----- src/bis_word_mem.sv -----
// Bitmap storage: one 64-bit word per entry, registered read, one write port.
// Per-word valid flops make clear immediate; an invalid word reads as zero.
`timescale 1ns / 1ps

module bis_word_mem #(
  parameter int NUM_WORDS = 16,
  parameter int WORD_AW   = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bis_pkg::mem_ctl_t           ctl,
  input  logic [WORD_AW-1:0]          rd_addr,
  input  logic [WORD_AW-1:0]          wr_addr,
  input  logic [bis_pkg::WORD_W-1:0]  wr_data,
  output logic [bis_pkg::WORD_W-1:0]  rd_data
);
  import bis_pkg::*;

  logic [WORD_W-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_r;
  logic [WORD_W-1:0] rd_data_r;
  logic rd_vld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ctl.clr_all) begin
        valid_r <= '0;
      end else if (ctl.wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ----- src/bis_ctrl.sv -----
// Sequencer for the bitmap set: read-modify-write of one word per item,
// word-by-word successor search and complement, count and lowest member.
// Depends on bis_pkg; drives the port of bis_word_mem.
`timescale 1ns / 1ps

module bis_ctrl #(
  parameter int CAPACITY = bis_pkg::DEF_CAPACITY,
  parameter int WORD_AW  = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [bis_pkg::OP_W-1:0]    in_operation,
  input  logic [bis_pkg::VAL_W-1:0]   in_value,
  output logic                        out_valid,
  output logic                        out_is_member,
  output logic [bis_pkg::VAL_W-1:0]   out_next_value,
  output logic                        out_next_found,
  output logic [bis_pkg::CNT_W-1:0]   out_element_count,
  output logic [bis_pkg::VAL_W-1:0]   out_smallest_member,
  output logic                        out_set_nonempty,
  output logic                        out_out_of_range,
  input  logic                        cfg_wr_en,
  input  logic [bis_pkg::VAL_W-1:0]   cfg_wr_data,
  output bis_pkg::mem_ctl_t           mem_ctl,
  output logic [WORD_AW-1:0]          mem_rd_addr,
  output logic [WORD_AW-1:0]          mem_wr_addr,
  output logic [bis_pkg::WORD_W-1:0]  mem_wr_data,
  input  logic [bis_pkg::WORD_W-1:0]  mem_rd_data
);
  import bis_pkg::*;

  localparam int CAP_TOP_I = (CAPACITY - 1 > (1 << VAL_W) - 1) ? (1 << VAL_W) - 1 : CAPACITY - 1;
  localparam logic [VAL_W-1:0] CAP_TOP = CAP_TOP_I[VAL_W-1:0];
  localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

  state_t state_r, state_nxt;
  op_t op_r, op_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [WORD_AW-1:0] widx_r, widx_nxt;
  logic [VAL_W-1:0] largest_r, largest_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [VAL_W-1:0] low_r, low_nxt;
  logic lv_r, lv_nxt;

  logic out_valid_r, out_is_member_r, out_next_found_r, out_oor_r, out_nonempty_r;
  logic [VAL_W-1:0] out_next_value_r, out_smallest_r;
  logic [CNT_W-1:0] out_count_r;

  logic fin, res_was, res_found, res_oor;
  logic [VAL_W-1:0] res_next;

  logic [VAL_W-1:0] top;
  logic [WORD_AW-1:0] top_word, in_word;
  logic last_word, was;
  logic [WORD_W-1:0] top_mask, above_mask, bit_sel, cmpl_word;
  ffs_t hit_access, hit_scan, hit_cmpl;
  logic [VAL_W-1:0] val_access, val_scan, val_cmpl;

  assign top       = (largest_r < CAP_TOP) ? largest_r : CAP_TOP;
  assign top_word  = top[WORD_LW +: WORD_AW];
  assign in_word   = in_value[WORD_LW +: WORD_AW];
  assign last_word = (widx_r == top_word);
  // bits 0..top within the last word, everything in earlier words
  assign top_mask   = last_word ? (ONES >> (~top[WORD_LW-1:0])) : ONES;
  // bits strictly above the value's bit
  assign above_mask = ~(ONES >> (~val_r[WORD_LW-1:0]));
  assign bit_sel    = WORD_W'(1) << val_r[WORD_LW-1:0];
  assign was        = mem_rd_data[val_r[WORD_LW-1:0]];
  assign cmpl_word  = mem_rd_data ^ top_mask;

  assign hit_access = find_first(mem_rd_data & above_mask & top_mask);
  assign hit_scan   = find_first(mem_rd_data & top_mask);
  assign hit_cmpl   = find_first(cmpl_word & top_mask);
  assign val_access = VAL_W'({widx_r, hit_access.idx});
  assign val_scan   = VAL_W'({widx_r, hit_scan.idx});
  assign val_cmpl   = VAL_W'({widx_r, hit_cmpl.idx});

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    widx_nxt    = widx_r;
    largest_nxt = largest_r;
    count_nxt   = count_r;
    low_nxt     = low_r;
    lv_nxt      = lv_r;
    mem_ctl     = '0;
    mem_rd_addr = '0;
    mem_wr_addr = widx_r;
    mem_wr_data = '0;
    fin         = 1'b0;
    res_was     = 1'b0;
    res_found   = 1'b0;
    res_next    = '0;
    res_oor     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (cfg_wr_en) begin
          largest_nxt     = cfg_wr_data;
          mem_ctl.clr_all = 1'b1;
          count_nxt       = '0;
          low_nxt         = '0;
          lv_nxt          = 1'b0;
        end else if (start) begin
          op_nxt  = op_t'(in_operation);
          val_nxt = in_value;
          case (op_t'(in_operation))
            OP_INSERT, OP_REMOVE, OP_TEST, OP_SUCC: begin
              if (in_value > top) begin
                fin     = 1'b1;
                res_oor = 1'b1;
              end else begin
                mem_ctl.rd_en = 1'b1;
                mem_rd_addr   = in_word;
                widx_nxt      = in_word;
                state_nxt     = ST_ACCESS;
              end
            end
            OP_CLEAR: begin
              mem_ctl.clr_all = 1'b1;
              count_nxt       = '0;
              low_nxt         = '0;
              lv_nxt          = 1'b0;
              fin             = 1'b1;
            end
            OP_COMPL: begin
              // members all lie in 0..top, so the complement holds the rest
              count_nxt     = {1'b0, top} + CNT_W'(1) - count_r;
              low_nxt       = '0;
              lv_nxt        = 1'b0;
              mem_ctl.rd_en = 1'b1;
              mem_rd_addr   = '0;
              widx_nxt      = '0;
              state_nxt     = ST_CMPL;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end

      ST_ACCESS: begin
        res_was = was;
        case (op_r)
          OP_INSERT: begin
            mem_ctl.wr_en = 1'b1;
            mem_wr_data   = mem_rd_data | bit_sel;
            if (!was) begin
              count_nxt = count_r + 1'b1;
            end
            if (!lv_r || low_r > val_r) begin
              low_nxt = val_r;
              lv_nxt  = 1'b1;
            end
            fin = 1'b1;
          end
          OP_REMOVE: begin
            if (was) begin
              mem_ctl.wr_en = 1'b1;
              mem_wr_data   = mem_rd_data & ~bit_sel;
              count_nxt     = count_r - 1'b1;
              if (lv_r && low_r == val_r) begin
                if (hit_access.found) begin
                  low_nxt = val_access;
                  fin     = 1'b1;
                end else if (!last_word) begin
                  mem_ctl.rd_en = 1'b1;
                  mem_rd_addr   = widx_r + 1'b1;
                  widx_nxt      = widx_r + 1'b1;
                  state_nxt     = ST_SCAN;
                end else begin
                  low_nxt = '0;
                  lv_nxt  = 1'b0;
                  fin     = 1'b1;
                end
              end else begin
                fin = 1'b1;
              end
            end else begin
              fin = 1'b1;
            end
          end
          OP_SUCC: begin
            if (was && hit_access.found) begin
              res_found = 1'b1;
              res_next  = val_access;
              fin       = 1'b1;
            end else if (was && !last_word) begin
              mem_ctl.rd_en = 1'b1;
              mem_rd_addr   = widx_r + 1'b1;
              widx_nxt      = widx_r + 1'b1;
              state_nxt     = ST_SCAN;
            end else begin
              fin = 1'b1;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      ST_SCAN: begin
        // only entered when the value was a member
        res_was = 1'b1;
        if (hit_scan.found) begin
          if (op_r == OP_SUCC) begin
            res_found = 1'b1;
            res_next  = val_scan;
          end else begin
            low_nxt = val_scan;
          end
          fin = 1'b1;
        end else if (last_word) begin
          if (op_r != OP_SUCC) begin
            low_nxt = '0;
            lv_nxt  = 1'b0;
          end
          fin = 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = widx_r + 1'b1;
          widx_nxt      = widx_r + 1'b1;
        end
      end

      ST_CMPL: begin
        mem_ctl.wr_en = 1'b1;
        mem_wr_data   = cmpl_word;
        if (!lv_r && hit_cmpl.found) begin
          lv_nxt  = 1'b1;
          low_nxt = val_cmpl;
        end
        if (last_word) begin
          fin = 1'b1;
        end else begin
          mem_ctl.rd_en = 1'b1;
          mem_rd_addr   = widx_r + 1'b1;
          widx_nxt      = widx_r + 1'b1;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_nxt = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      largest_r   <= LARGEST_RST;
      count_r     <= '0;
      low_r       <= '0;
      lv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      largest_r   <= largest_nxt;
      count_r     <= count_nxt;
      low_r       <= low_nxt;
      lv_r        <= lv_nxt;
      out_valid_r <= fin;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    val_r  <= val_nxt;
    widx_r <= widx_nxt;
    if (fin) begin
      out_is_member_r  <= res_was;
      out_next_value_r <= res_next;
      out_next_found_r <= res_found;
      out_count_r      <= count_nxt;
      out_smallest_r   <= lv_nxt ? low_nxt : '0;
      out_nonempty_r   <= lv_nxt;
      out_oor_r        <= res_oor;
    end
  end

  assign busy                = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_is_member       = out_is_member_r;
  assign out_next_value      = out_next_value_r;
  assign out_next_found      = out_next_found_r;
  assign out_element_count   = out_count_r;
  assign out_smallest_member = out_smallest_r;
  assign out_set_nonempty    = out_nonempty_r;
  assign out_out_of_range    = out_oor_r;

endmodule

// ----- src/bitmap_integer_set.sv -----
// Top level of the bitmap integer set: sequencer plus bitmap word memory.
// Depends on bis_pkg, bis_ctrl and bis_word_mem.
//
// Usage:
//   Input: drive in_operation / in_value and raise start; the item is taken
//   at a clock edge where start is high and busy is low.
//   Output: each item gives one result, shown for a single cycle with
//   out_valid high. The receiver cannot stall; results must be taken then.
//   Config: cfg_wr_en with cfg_wr_data sets the largest value and empties
//   the set; write only while the block is idle.
// Sequence (W = words of 64 bits up to the largest value, 16 at full size):
//   Out-of-range value, clear, unused codes: result in the cycle after
//   accept, busy stays low.
//   Insert, remove, member test, successor: the value's own word is read, then
//   checked and, for insert and remove, written back; a successor search or a
//   remove of the smallest member that goes on past it reads one further word
//   per cycle, up to word W-1. Complement: one read-modify-write of a word per cycle.
//   The single read port of the bitmap memory sets this word-by-word pace.
// Reset: synchronous, active low; empties the set at once (per-word valid
//   flags) and sets the largest value to 1023.
`timescale 1ns / 1ps

module bitmap_integer_set #(
  parameter int CAPACITY = bis_pkg::DEF_CAPACITY
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [bis_pkg::OP_W-1:0]   in_operation,
  input  logic [bis_pkg::VAL_W-1:0]  in_value,
  output logic                       out_valid,
  output logic                       out_is_member,
  output logic [bis_pkg::VAL_W-1:0]  out_next_value,
  output logic                       out_next_found,
  output logic [bis_pkg::CNT_W-1:0]  out_element_count,
  output logic [bis_pkg::VAL_W-1:0]  out_smallest_member,
  output logic                       out_set_nonempty,
  output logic                       out_out_of_range,
  input  logic                       cfg_wr_en,
  input  logic [bis_pkg::VAL_W-1:0]  cfg_wr_data
);
  import bis_pkg::*;

  // values stop at 2**VAL_W - 1, so bits beyond that are never stored
  localparam int EFF_BITS  = (CAPACITY < (1 << VAL_W)) ? CAPACITY : (1 << VAL_W);
  localparam int NUM_WORDS = (EFF_BITS + WORD_W - 1) / WORD_W;
  localparam int WORD_AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;

  mem_ctl_t mem_ctl;
  logic [WORD_AW-1:0] mem_rd_addr, mem_wr_addr;
  logic [WORD_W-1:0] mem_wr_data, mem_rd_data;

  bis_ctrl #(
    .CAPACITY (CAPACITY),
    .WORD_AW  (WORD_AW)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_value            (in_value),
    .out_valid           (out_valid),
    .out_is_member       (out_is_member),
    .out_next_value      (out_next_value),
    .out_next_found      (out_next_found),
    .out_element_count   (out_element_count),
    .out_smallest_member (out_smallest_member),
    .out_set_nonempty    (out_set_nonempty),
    .out_out_of_range    (out_out_of_range),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .mem_ctl             (mem_ctl),
    .mem_rd_addr         (mem_rd_addr),
    .mem_wr_addr         (mem_wr_addr),
    .mem_wr_data         (mem_wr_data),
    .mem_rd_data         (mem_rd_data)
  );

  bis_word_mem #(
    .NUM_WORDS (NUM_WORDS),
    .WORD_AW   (WORD_AW)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (mem_rd_addr),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_data (mem_rd_data)
  );

endmodule

// ----- src/bis_checker.sv -----
// Port-level checks for the bitmap integer set, bound to the top level.
// Depends on bis_pkg and bitmap_integer_set.
`timescale 1ns / 1ps

module bis_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic                       out_is_member,
  input logic [bis_pkg::VAL_W-1:0]  out_next_value,
  input logic                       out_next_found,
  input logic [bis_pkg::CNT_W-1:0]  out_element_count,
  input logic [bis_pkg::VAL_W-1:0]  out_smallest_member,
  input logic                       out_set_nonempty,
  input logic                       out_out_of_range
);
  import bis_pkg::*;

  // an accepted item either finishes at once or holds the block busy
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither busy nor answered");

  a_count_vs_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_element_count == '0) == !out_set_nonempty))
    else $error("element count disagrees with nonempty flag");

  a_empty_smallest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_set_nonempty) |-> (out_smallest_member == '0))
    else $error("smallest member nonzero on empty set");

  a_oor_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_out_of_range) |-> (!out_is_member && !out_next_found))
    else $error("out-of-range item reports membership or successor");

  // a successor lies above a member, so it is nonzero and the set is not empty
  a_succ_sane: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_next_found) |->
      (out_is_member && out_set_nonempty && out_next_value != '0))
    else $error("successor reported without a member below it");

endmodule

bind bitmap_integer_set bis_checker u_bis_checker (.*);

// ----- tb/sv/bitmap_integer_set_tb.sv -----
// Self-checking testbench for bitmap_integer_set: directed cases, then random traffic
// over several largest-value settings, each result checked against a local set model.
// Depends on bis_pkg and the bitmap_integer_set RTL.
`timescale 1ns / 1ps

module bitmap_integer_set_tb;
  import bis_pkg::*;

  localparam logic [OP_W-1:0] OP_SPARE_A  = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B  = 3'd7;
  localparam int unsigned     CYCLE_LIMIT = 400000;
  localparam int unsigned     DRAIN_WAIT  = 24;
  localparam int unsigned     MAX_REPORTS = 10;

  typedef struct packed {
    logic             is_member;
    logic [VAL_W-1:0] next_value;
    logic             next_found;
    logic [CNT_W-1:0] element_count;
    logic [VAL_W-1:0] smallest_member;
    logic             set_nonempty;
    logic             out_of_range;
  } set_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [OP_W-1:0]  in_operation = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic             out_valid;
  logic             out_is_member;
  logic [VAL_W-1:0] out_next_value;
  logic             out_next_found;
  logic [CNT_W-1:0] out_element_count;
  logic [VAL_W-1:0] out_smallest_member;
  logic             out_set_nonempty;
  logic             out_out_of_range;
  logic             cfg_wr_en = 1'b0;
  logic [VAL_W-1:0] cfg_wr_data = '0;

  // Set model
  bit [0:DEF_CAPACITY-1] member_map = '0;
  int unsigned           member_total = 0;
  int unsigned           least_member = 0;
  bit                    least_valid = 1'b0;
  int unsigned           top_limit = DEF_CAPACITY - 1;

  set_result_t pending_results[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned gap_pct = 0;

  bitmap_integer_set DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_operation       (in_operation),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_is_member      (out_is_member),
    .out_next_value     (out_next_value),
    .out_next_found     (out_next_found),
    .out_element_count  (out_element_count),
    .out_smallest_member(out_smallest_member),
    .out_set_nonempty   (out_set_nonempty),
    .out_out_of_range   (out_out_of_range),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // First member in from..top_limit
  function automatic bit find_member(input int unsigned from, output int unsigned at);
    at = 0;
    for (int unsigned j = from; j <= top_limit; j++) begin
      if (member_map[j]) begin
        at = j;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void empty_model();
    member_map   = '0;
    member_total = 0;
    least_member = 0;
    least_valid  = 1'b0;
  endfunction

  // Applies one operation to the model and returns the result it should give.
  function automatic set_result_t apply_op(input logic [OP_W-1:0] op,
                                           input logic [VAL_W-1:0] v);
    set_result_t r;
    int unsigned at;
    bit          was;
    r = '0;
    if (op <= OP_SUCC) begin
      if (v > top_limit) begin
        r.out_of_range = 1'b1;
      end else begin
        was = member_map[v];
        r.is_member = was;
        case (op)
          OP_INSERT: begin
            if (!least_valid || least_member > v) begin
              least_member = v;
              least_valid  = 1'b1;
            end
            if (!was) member_total++;
            member_map[v] = 1'b1;
          end
          OP_REMOVE: begin
            if (was) begin
              member_map[v] = 1'b0;
              member_total--;
              if (least_valid && least_member == v) begin
                least_valid  = (v < top_limit) && find_member(v + 1, at);
                least_member = least_valid ? at : 0;
              end
            end
          end
          OP_SUCC: begin
            if (was && v < top_limit && find_member(v + 1, at)) begin
              r.next_found = 1'b1;
              r.next_value = at[VAL_W-1:0];
            end
          end
          default: ;
        endcase
      end
    end else if (op == OP_CLEAR) begin
      empty_model();
    end else if (op == OP_COMPL) begin
      member_total = 0;
      least_valid  = 1'b0;
      least_member = 0;
      for (int unsigned j = 0; j <= top_limit; j++) begin
        member_map[j] = ~member_map[j];
        if (member_map[j]) begin
          if (!least_valid) begin
            least_valid  = 1'b1;
            least_member = j;
          end
          member_total++;
        end
      end
    end
    r.element_count   = member_total[CNT_W-1:0];
    r.smallest_member = least_valid ? least_member[VAL_W-1:0] : '0;
    r.set_nonempty    = least_valid;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    set_result_t got;
    set_result_t want;
    if (rst_n && out_valid) begin
      got = {out_is_member, out_next_value, out_next_found, out_element_count,
             out_smallest_member, out_set_nonempty, out_out_of_range};
      if (pending_results.size() == 0) begin
        if (mismatch_count < MAX_REPORTS)
          $display("%0t: result with nothing pending: %p", $time, got);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: mismatch", $time);
            $display("  exp mem=%0b next=%0d found=%0b cnt=%0d min=%0d nonempty=%0b oor=%0b",
                     want.is_member, want.next_value, want.next_found, want.element_count,
                     want.smallest_member, want.set_nonempty, want.out_of_range);
            $display("  got mem=%0b next=%0d found=%0b cnt=%0d min=%0d nonempty=%0b oor=%0b",
                     got.is_member, got.next_value, got.next_found, got.element_count,
                     got.smallest_member, got.set_nonempty, got.out_of_range);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Presents one item, waits until it is taken, then maybe idles.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] v);
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_op(op, v));
    if ($urandom_range(0, 99) < gap_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < gap_pct);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_largest(input int unsigned lim);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lim[VAL_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    top_limit = lim;
    empty_model();
  endtask

  // Mostly members (so successor and remove do real work), some oor values.
  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    int unsigned s;
    int unsigned j;
    r = $urandom_range(0, 99);
    if (r < 10) return VAL_W'($urandom_range(0, DEF_CAPACITY - 1));
    if (least_valid && r < 20) return least_member[VAL_W-1:0];
    if (member_total != 0 && r < 60) begin
      s = $urandom_range(0, top_limit);
      for (int unsigned k = 0; k <= top_limit; k++) begin
        j = (s + k) % (top_limit + 1);
        if (member_map[j]) return j[VAL_W-1:0];
      end
    end
    return VAL_W'($urandom_range(0, top_limit));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_INSERT;
    if (r < 52) return OP_REMOVE;
    if (r < 62) return OP_TEST;
    if (r < 84) return OP_SUCC;
    if (r < 87) return OP_CLEAR;
    if (r < 93) return OP_COMPL;
    return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
  endfunction

  // Reset value of the register, word ends of a full-size set, spare codes.
  task automatic test_full_range_cases();
    gap_pct = 0;
    send_item(OP_TEST,    10'd1023);
    send_item(OP_INSERT,  10'd1023);
    send_item(OP_INSERT,  10'd0);
    send_item(OP_INSERT,  10'd0);
    send_item(OP_INSERT,  10'd512);
    send_item(OP_SUCC,    10'd0);
    send_item(OP_SUCC,    10'd512);
    send_item(OP_SUCC,    10'd1023);
    send_item(OP_SUCC,    10'd5);
    send_item(OP_REMOVE,  10'd0);
    send_item(OP_REMOVE,  10'd7);
    send_item(OP_SPARE_A, 10'd1023);
    send_item(OP_SPARE_B, 10'd512);
    send_item(OP_COMPL,   10'd300);
    send_item(OP_SUCC,    10'd0);
    send_item(OP_CLEAR,   10'd1023);
  endtask

  // Smallest register value and a set that crosses one word boundary.
  task automatic test_narrow_range_cases();
    write_largest(0);
    send_item(OP_INSERT, 10'd1);
    send_item(OP_INSERT, 10'd0);
    send_item(OP_SUCC,   10'd0);
    send_item(OP_COMPL,  10'd0);
    send_item(OP_COMPL,  10'd0);
    send_item(OP_REMOVE, 10'd0);
    write_largest(64);
    send_item(OP_INSERT, 10'd63);
    send_item(OP_INSERT, 10'd64);
    send_item(OP_INSERT, 10'd65);
    send_item(OP_SUCC,   10'd63);
    send_item(OP_REMOVE, 10'd63);
    send_item(OP_COMPL,  10'd0);
    send_item(OP_SUCC,   10'd63);
  endtask

  task automatic test_random_mix(input int unsigned lim, input int unsigned pct,
                                 input int unsigned count);
    logic [OP_W-1:0] op;
    write_largest(lim);
    gap_pct = pct;
    repeat (count) begin
      op = pick_op();
      send_item(op, pick_value());
    end
  endtask

  initial begin
    int unsigned limits[10];
    int unsigned pcts[10];
    limits = '{1023, 0, 1, 63, 64, 127, 700, 1022, 0, 1023};
    pcts   = '{0, 81, 7, 0, 81, 7, 81, 0, 7, 81};
    limits[8] = $urandom_range(2, DEF_CAPACITY - 2);
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_full_range_cases();
    test_narrow_range_cases();
    for (int i = 0; i < 10; i++)
      test_random_mix(limits[i], pcts[i], 160);
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- bitmap_integer_set.f -----
src/bis_pkg.sv
src/bis_word_mem.sv
src/bis_ctrl.sv
src/bitmap_integer_set.sv
src/bis_checker.sv
tb/sv/bitmap_integer_set_tb.sv
